### design/assert_macros.svh
// assertion macros shared by gts_stats and gts_rowbuf
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/gts_pkg.sv
// shared types, constants and helpers for the grouped temperature statistics block
package gts_pkg;

  localparam int YEAR_W     = 16;
  localparam int MONTH_W    = 4;
  localparam int READ_W     = 8;
  localparam int SUM_W      = 28;
  localparam int CNT_OUT_W  = 20;
  localparam int FILTER_W   = 5;
  localparam int COUNT_WIDTH_DEF = 20;

  // rows one item can produce: old month, old year, flushed month, flushed year
  localparam int ROWS     = 4;
  localparam int ROW_IDX_W = $clog2(ROWS);

  localparam logic [FILTER_W-1:0] FILTER_RESET = 5'h1F;

  localparam logic KIND_MONTH = 1'b0;
  localparam logic KIND_YEAR  = 1'b1;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 80;

  typedef struct packed {
    logic                     kind;
    logic [YEAR_W-1:0]        key;
    logic signed [READ_W-1:0] lo;
    logic signed [READ_W-1:0] hi;
    logic signed [SUM_W-1:0]  total;
    logic [CNT_OUT_W-1:0]     samples;
  } row_t;

  // negative passes all months, zero blocks all, positive matches one key
  function automatic logic month_pass(input logic [FILTER_W-1:0] filt,
                                      input logic [MONTH_W-1:0] month);
    logic pass;
    if (filt[FILTER_W-1]) begin
      pass = 1'b1;
    end else if (filt == '0) begin
      pass = 1'b0;
    end else begin
      pass = (month == filt[MONTH_W-1:0]);
    end
    return pass;
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] t,
                                                      input logic signed [READ_W-1:0] r);
    logic signed [SUM_W:0] s;
    logic signed [SUM_W-1:0] res;
    s = (SUM_W+1)'(t) + (SUM_W+1)'(r);
    if (s[SUM_W] != s[SUM_W-1]) begin
      res = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      res = s[SUM_W-1:0];
    end
    return res;
  endfunction

endpackage

### design/gts_stats.sv
// month and year group state, and the rows one item produces
module gts_stats #(
  parameter int COUNT_WIDTH = gts_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic [gts_pkg::YEAR_W-1:0]          rec_year,
  input  logic [gts_pkg::MONTH_W-1:0]         rec_month,
  input  logic signed [gts_pkg::READ_W-1:0]   reading,
  input  logic                                end_of_data,
  input  logic [gts_pkg::FILTER_W-1:0]        month_filter,
  output gts_pkg::row_t                       rows [gts_pkg::ROWS],
  output logic [gts_pkg::ROWS-1:0]            row_mask
);

  `include "assert_macros.svh"

  localparam int XW = (COUNT_WIDTH > gts_pkg::CNT_OUT_W) ? COUNT_WIDTH : gts_pkg::CNT_OUT_W;

  logic                               open_r, open_nxt;
  logic [gts_pkg::YEAR_W-1:0]         cur_year_r, cur_year_nxt;
  logic [gts_pkg::MONTH_W-1:0]        cur_month_r, cur_month_nxt;
  logic signed [gts_pkg::READ_W-1:0]  m_lo_r, m_lo_nxt, m_hi_r, m_hi_nxt;
  logic signed [gts_pkg::READ_W-1:0]  y_lo_r, y_lo_nxt, y_hi_r, y_hi_nxt;
  logic signed [gts_pkg::SUM_W-1:0]   m_sum_r, m_sum_nxt, y_sum_r, y_sum_nxt;
  logic [COUNT_WIDTH-1:0]             m_cnt_r, m_cnt_nxt, y_cnt_r, y_cnt_nxt;
  logic                               same_year, same_month, start_m, start_y;

  function automatic logic [gts_pkg::CNT_OUT_W-1:0] cnt_out(input logic [COUNT_WIDTH-1:0] c);
    logic [XW-1:0] w;
    w = XW'(c);
    return w[gts_pkg::CNT_OUT_W-1:0];
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] cnt_inc(input logic [COUNT_WIDTH-1:0] c);
    return (c == '1) ? c : c + COUNT_WIDTH'(1);
  endfunction

  assign same_year  = (rec_year == cur_year_r);
  assign same_month = (rec_month == cur_month_r);
  assign start_y    = !open_r || !same_year;
  assign start_m    = start_y || !same_month;

  always_comb begin
    cur_year_nxt  = rec_year;
    cur_month_nxt = rec_month;
    open_nxt      = !end_of_data;
    if (start_m) begin
      m_lo_nxt  = reading;
      m_hi_nxt  = reading;
      m_sum_nxt = gts_pkg::SUM_W'(reading);
      m_cnt_nxt = COUNT_WIDTH'(1);
    end else begin
      m_lo_nxt  = (reading < m_lo_r) ? reading : m_lo_r;
      m_hi_nxt  = (reading > m_hi_r) ? reading : m_hi_r;
      m_sum_nxt = gts_pkg::sat_add(m_sum_r, reading);
      m_cnt_nxt = cnt_inc(m_cnt_r);
    end
    if (start_y) begin
      y_lo_nxt  = reading;
      y_hi_nxt  = reading;
      y_sum_nxt = gts_pkg::SUM_W'(reading);
      y_cnt_nxt = COUNT_WIDTH'(1);
    end else begin
      y_lo_nxt  = (reading < y_lo_r) ? reading : y_lo_r;
      y_hi_nxt  = (reading > y_hi_r) ? reading : y_hi_r;
      y_sum_nxt = gts_pkg::sat_add(y_sum_r, reading);
      y_cnt_nxt = cnt_inc(y_cnt_r);
    end
  end

  // rows in output order: closed month, closed year, flushed month, flushed year
  always_comb begin
    rows[0] = '{gts_pkg::KIND_MONTH, gts_pkg::YEAR_W'(cur_month_r), m_lo_r, m_hi_r,
                m_sum_r, cnt_out(m_cnt_r)};
    rows[1] = '{gts_pkg::KIND_YEAR, cur_year_r, y_lo_r, y_hi_r, y_sum_r, cnt_out(y_cnt_r)};
    rows[2] = '{gts_pkg::KIND_MONTH, gts_pkg::YEAR_W'(rec_month), m_lo_nxt, m_hi_nxt,
                m_sum_nxt, cnt_out(m_cnt_nxt)};
    rows[3] = '{gts_pkg::KIND_YEAR, rec_year, y_lo_nxt, y_hi_nxt, y_sum_nxt,
                cnt_out(y_cnt_nxt)};
    row_mask[0] = open_r && start_m && gts_pkg::month_pass(month_filter, cur_month_r);
    row_mask[1] = open_r && start_y;
    row_mask[2] = end_of_data && gts_pkg::month_pass(month_filter, rec_month);
    row_mask[3] = end_of_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
    end else if (adv) begin
      open_r <= open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cur_year_r  <= cur_year_nxt;
      cur_month_r <= cur_month_nxt;
      m_lo_r      <= m_lo_nxt;
      m_hi_r      <= m_hi_nxt;
      m_sum_r     <= m_sum_nxt;
      m_cnt_r     <= m_cnt_nxt;
      y_lo_r      <= y_lo_nxt;
      y_hi_r      <= y_hi_nxt;
      y_sum_r     <= y_sum_nxt;
      y_cnt_r     <= y_cnt_nxt;
    end
  end

  `ASSERT_NEXT(a_flush_closes, adv && end_of_data, !open_r,
               "group still open after end of data")
  `ASSERT_SAME(a_year_row_implies_month_check, row_mask[1], start_m,
               "year closed without closing the month")

endmodule

### design/gts_rowbuf.sv
// holds the rows of one item and hands them out one per transfer
module gts_rowbuf (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           load,
  input  gts_pkg::row_t                  rows [gts_pkg::ROWS],
  input  logic [gts_pkg::ROWS-1:0]       row_mask,
  output logic                           done,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output gts_pkg::row_t                  out_row,
  output logic                           out_last
);

  `include "assert_macros.svh"

  gts_pkg::row_t                  row_r [gts_pkg::ROWS];
  logic [gts_pkg::ROWS-1:0]       pend_r, pend_nxt, rest;
  logic [gts_pkg::ROW_IDX_W-1:0]  head;
  logic                           take;

  // lowest pending slot goes first
  always_comb begin
    head = '0;
    for (int i = gts_pkg::ROWS - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        head = gts_pkg::ROW_IDX_W'(i);
      end
    end
  end

  always_comb begin
    rest       = pend_r;
    rest[head] = 1'b0;
  end

  assign out_tvalid = |pend_r;
  assign out_row    = row_r[head];
  assign out_last   = (rest == '0);
  assign take       = out_tvalid && out_tready;
  assign done       = !out_tvalid || (take && out_last);

  always_comb begin
    if (load) begin
      pend_nxt = row_mask;
    end else if (take) begin
      pend_nxt = rest;
    end else begin
      pend_nxt = pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      row_r <= rows;
    end
  end

  `ASSERT_SAME(a_load_only_when_drained, load, done,
               "rows loaded over pending rows")
  `ASSERT_NEXT(a_last_empties, take && out_last && !load, !out_tvalid,
               "rows left after the last transfer")

endmodule

### design/grouped_temperature_stats.sv
// top level of the grouped temperature statistics block
//
// Input stream: one record per transfer; in_tdata holds year, month and reading,
// in_tlast marks end of data. Output stream: one statistics row per transfer;
// out_tuser tells a month row (0) from a year row (1), out_tlast marks the last
// row caused by one record. cfg_wr_en writes the month filter (-1 all months,
// 0 none, otherwise one month key); write it only while the block is idle.
// A record waits in the input register until the row buffer is done with earlier
// rows, then updates the month and year groups and loads its rows (zero to four)
// into the row buffer, whose registers hold them until they are taken.
// Throughput: one record per cycle while each record yields at most one row and
// the receiver does not stall; a record with more rows holds the single output
// port until its last row is taken; the next record waits in the input register.
// Reset clears the filter to -1 and leaves no group open. When the receiver
// stalls, the current row holds and in_tready drops once the input register fills.
module grouped_temperature_stats #(
  parameter int COUNT_WIDTH = gts_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // rec_year [15:0], rec_month [19:16], reading [27:20], zero pad [31:28]
  input  logic [gts_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // row_key [15:0], min_reading [23:16], max_reading [31:24],
  // reading_sum [59:32], sample_count [79:60]
  output logic [gts_pkg::OUT_DATA_W-1:0]    out_tdata,
  // row_kind [0]
  output logic                              out_tuser,
  output logic                              out_tlast,
  input  logic                              cfg_wr_en,
  input  logic [gts_pkg::FILTER_W-1:0]      cfg_wr_data
);

  logic [gts_pkg::FILTER_W-1:0]        filter_r;
  logic                                inv_r;
  logic [gts_pkg::YEAR_W-1:0]          year_r;
  logic [gts_pkg::MONTH_W-1:0]         month_r;
  logic signed [gts_pkg::READ_W-1:0]   reading_r;
  logic                                eod_r;
  logic                                adv, buf_done, in_take;
  gts_pkg::row_t                       rows [gts_pkg::ROWS];
  logic [gts_pkg::ROWS-1:0]            row_mask;
  gts_pkg::row_t                       out_row;

  assign adv       = inv_r && buf_done;
  assign in_tready = !inv_r || adv;
  assign in_take   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_r <= gts_pkg::FILTER_RESET;
    end else if (cfg_wr_en) begin
      filter_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= 1'b0;
    end else if (in_take) begin
      inv_r <= 1'b1;
    end else if (adv) begin
      inv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      year_r    <= in_tdata[15:0];
      month_r   <= in_tdata[19:16];
      reading_r <= in_tdata[27:20];
      eod_r     <= in_tlast;
    end
  end

  gts_stats #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_stats (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .rec_year     (year_r),
    .rec_month    (month_r),
    .reading      (reading_r),
    .end_of_data  (eod_r),
    .month_filter (filter_r),
    .rows         (rows),
    .row_mask     (row_mask)
  );

  gts_rowbuf u_rowbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (adv),
    .rows       (rows),
    .row_mask   (row_mask),
    .done       (buf_done),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_row    (out_row),
    .out_last   (out_tlast)
  );

  assign out_tuser = out_row.kind;
  assign out_tdata = {out_row.samples, out_row.total, out_row.hi, out_row.lo, out_row.key};

endmodule

### dv/tb_grouped_temperature_stats.sv
// testbench for grouped_temperature_stats: random record streams checked against a row predictor
module tb_grouped_temperature_stats;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD    = 12;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 200_000;
  localparam int PHASE_ITEMS   = 55;
  localparam int NUM_PHASES    = 6;

  typedef struct packed {
    logic signed [gts_pkg::READ_W-1:0] lo;
    logic signed [gts_pkg::READ_W-1:0] hi;
    logic signed [gts_pkg::SUM_W-1:0]  total;
    logic [gts_pkg::CNT_OUT_W-1:0]     samples;
  } group_stats_t;

  typedef struct packed {
    gts_pkg::row_t row;
    logic          last;
  } expected_row_t;

  // tracks the open month and year groups and the rows they should produce
  class group_stats_tracker;
    logic signed [gts_pkg::FILTER_W-1:0] filter;
    logic                                grp_active;
    logic [gts_pkg::YEAR_W-1:0]          cur_year;
    logic [gts_pkg::MONTH_W-1:0]         cur_month;
    group_stats_t                        month_grp;
    group_stats_t                        year_grp;
    expected_row_t                       run_rows[$];
    expected_row_t                       pending_rows[$];
    int                                  errors;

    function new();
      filter     = '1;
      grp_active = 1'b0;
      cur_year   = '0;
      cur_month  = '0;
      month_grp  = '0;
      year_grp   = '0;
      errors     = 0;
    endfunction

    function void set_filter(logic [gts_pkg::FILTER_W-1:0] value);
      filter = value;
    endfunction

    function group_stats_t open_group(logic signed [gts_pkg::READ_W-1:0] r);
      group_stats_t g;
      g.lo      = r;
      g.hi      = r;
      g.total   = gts_pkg::SUM_W'(r);
      g.samples = gts_pkg::CNT_OUT_W'(1);
      return g;
    endfunction

    function group_stats_t add_reading(group_stats_t g,
                                       logic signed [gts_pkg::READ_W-1:0] r);
      int s;
      s = int'(g.total) + int'(r);
      if (s > (2 ** (gts_pkg::SUM_W - 1)) - 1) s = (2 ** (gts_pkg::SUM_W - 1)) - 1;
      if (s < -(2 ** (gts_pkg::SUM_W - 1))) s = -(2 ** (gts_pkg::SUM_W - 1));
      if (r < g.lo) g.lo = r;
      if (r > g.hi) g.hi = r;
      g.total = s[gts_pkg::SUM_W-1:0];
      if (g.samples != '1) g.samples = g.samples + 1'b1;
      return g;
    endfunction

    function void push_row(logic kind, logic [gts_pkg::YEAR_W-1:0] key, group_stats_t g);
      expected_row_t e;
      e.row.kind    = kind;
      e.row.key     = key;
      e.row.lo      = g.lo;
      e.row.hi      = g.hi;
      e.row.total   = g.total;
      e.row.samples = g.samples;
      e.last        = 1'b0;
      run_rows.push_back(e);
    endfunction

    // month rows go through the filter, year rows never do
    function void close_month();
      logic pass;
      pass = (filter < 0) || (filter != 0 && {1'b0, cur_month} == filter);
      if (pass) begin
        push_row(gts_pkg::KIND_MONTH,
                 {{(gts_pkg::YEAR_W-gts_pkg::MONTH_W){1'b0}}, cur_month}, month_grp);
      end
    endfunction

    function void close_year();
      push_row(gts_pkg::KIND_YEAR, cur_year, year_grp);
    endfunction

    function void take_record(logic [gts_pkg::YEAR_W-1:0] y, logic [gts_pkg::MONTH_W-1:0] m,
                              logic signed [gts_pkg::READ_W-1:0] r, logic eod);
      run_rows.delete();
      if (!grp_active) begin
        month_grp  = open_group(r);
        year_grp   = open_group(r);
        cur_month  = m;
        cur_year   = y;
        grp_active = 1'b1;
      end else if (y == cur_year && m == cur_month) begin
        month_grp = add_reading(month_grp, r);
        year_grp  = add_reading(year_grp, r);
      end else if (y == cur_year) begin
        close_month();
        month_grp = open_group(r);
        cur_month = m;
        year_grp  = add_reading(year_grp, r);
      end else begin
        close_month();
        close_year();
        month_grp = open_group(r);
        year_grp  = open_group(r);
        cur_month = m;
        cur_year  = y;
      end
      if (eod) begin
        close_month();
        close_year();
        grp_active = 1'b0;
      end
      if (run_rows.size() > 0) run_rows[run_rows.size()-1].last = 1'b1;
      foreach (run_rows[i]) pending_rows.push_back(run_rows[i]);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void match_row(logic kind, logic [gts_pkg::OUT_DATA_W-1:0] data, logic last);
      expected_row_t want;
      if (pending_rows.size() == 0) begin
        $error("row transfer with nothing pending: kind %0d key %0h", kind, data[15:0]);
        errors++;
        return;
      end
      want = pending_rows.pop_front();
      check_field("row_kind", want.row.kind, kind);
      check_field("row_key", want.row.key, data[15:0]);
      check_field("min_reading", $unsigned(want.row.lo), data[23:16]);
      check_field("max_reading", $unsigned(want.row.hi), data[31:24]);
      check_field("reading_sum", $unsigned(want.row.total), data[59:32]);
      check_field("sample_count", want.row.samples, data[79:60]);
      check_field("last_of_run", want.last, last);
    endfunction

    function bit drained();
      return pending_rows.size() == 0;
    endfunction
  endclass

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_tvalid = 1'b0;
  logic                               in_tready;
  logic [gts_pkg::IN_DATA_W-1:0]      in_tdata = '0;
  logic                               in_tlast = 1'b0;
  logic                               out_tvalid;
  logic                               out_tready = 1'b0;
  logic [gts_pkg::OUT_DATA_W-1:0]     out_tdata;
  logic                               out_tuser;
  logic                               out_tlast;
  logic                               cfg_wr_en = 1'b0;
  logic [gts_pkg::FILTER_W-1:0]       cfg_wr_data = '0;

  group_stats_tracker tracker;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int phase_items = 0;
  int cycles = 0;

  grouped_temperature_stats DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // transfers on both sides are seen here, before any flop updates of this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        tracker.take_record(in_tdata[15:0], in_tdata[19:16], in_tdata[27:20], in_tlast);
      end
      if (out_tvalid && out_tready) begin
        tracker.match_row(out_tuser, out_tdata, out_tlast);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_grouped_temperature_stats: done, errors");
      $finish;
    end
  end

  task automatic send_record(logic [gts_pkg::YEAR_W-1:0] y, logic [gts_pkg::MONTH_W-1:0] m,
                             logic [gts_pkg::READ_W-1:0] r, logic eod);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(gts_pkg::IN_DATA_W-gts_pkg::YEAR_W-gts_pkg::MONTH_W-gts_pkg::READ_W){1'b0}},
                  r, m, y};
    in_tlast  <= eod;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    phase_items++;
  endtask

  // hold the sender until every pending row has come out, then let the pipe settle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (!tracker.drained()) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_filter(logic [gts_pkg::FILTER_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.set_filter(value);
  endtask

  // time-ordered months of one or more years, closed with end of data half the time
  task automatic send_sequence();
    logic [gts_pkg::YEAR_W-1:0]  y;
    logic [gts_pkg::MONTH_W-1:0] m;
    int                          months;
    int                          step;
    y = ($urandom_range(3) == 0) ? gts_pkg::YEAR_W'($urandom())
                                 : gts_pkg::YEAR_W'($urandom_range(1950, 2050));
    m = gts_pkg::MONTH_W'($urandom_range(1, 12));
    months = $urandom_range(1, 6);
    repeat (months) begin
      repeat ($urandom_range(1, 5)) send_record(y, m, gts_pkg::READ_W'($urandom()), 1'b0);
      step = $urandom_range(1, 2);
      if (m == 12 || $urandom_range(7) == 0) begin
        y = y + 1'b1;
        m = gts_pkg::MONTH_W'(1);
      end else begin
        m = (m + step > 12) ? gts_pkg::MONTH_W'(12) : gts_pkg::MONTH_W'(m + step);
      end
    end
    if ($urandom_range(1)) send_record(y, m, gts_pkg::READ_W'($urandom()), 1'b1);
  endtask

  initial begin
    logic [gts_pkg::FILTER_W-1:0] phase_filter[NUM_PHASES];
    phase_filter = '{5'd0, 5'd15, 5'h10, 5'd12, 5'd3, 5'h1F};
    tracker = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, odd month keys, year wrap and flushes under the reset filter
    tx_idle_pct = 23;
    rx_idle_pct = 82;
    send_record(16'd2000, 4'd1, 8'h80, 1'b0);
    send_record(16'd2000, 4'd1, 8'h7F, 1'b0);
    send_record(16'd2000, 4'd2, 8'h00, 1'b0);
    send_record(16'd2000, 4'd0, 8'h05, 1'b0);
    send_record(16'd2000, 4'd15, 8'hFF, 1'b0);
    send_record(16'd2000, 4'd13, 8'h03, 1'b0);
    send_record(16'd2001, 4'd13, 8'h0A, 1'b0);
    send_record(16'd2001, 4'd13, 8'hFB, 1'b1);
    send_record(16'd0, 4'd1, 8'h01, 1'b1);
    send_record(16'hFFFF, 4'd12, 8'h80, 1'b0);
    // year change and flush on the same record: four rows
    send_record(16'd0, 4'd12, 8'h7F, 1'b1);
    send_record(16'd32767, 4'd5, 8'h01, 1'b0);
    send_record(16'd32768, 4'd5, 8'h02, 1'b0);
    send_record(16'd32768, 4'd5, 8'h03, 1'b1);
    send_record(16'hFFFF, 4'd15, 8'h7F, 1'b1);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 2) begin
        tx_idle_pct = 23;
        rx_idle_pct = 82;
      end else if (p < 4) begin
        tx_idle_pct = 82;
        rx_idle_pct = 23;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_filter(phase_filter[p]);
      phase_items = 0;
      // a short run on the filtered key so matching month rows show up
      send_record(16'd777, phase_filter[p][gts_pkg::MONTH_W-1:0], 8'h0A, 1'b0);
      send_record(16'd777, phase_filter[p][gts_pkg::MONTH_W-1:0] + 1'b1, 8'h14, 1'b0);
      send_record(16'd777, phase_filter[p][gts_pkg::MONTH_W-1:0], 8'h1E, 1'b1);
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(99) < 85) begin
          send_sequence();
        end else begin
          send_record(gts_pkg::YEAR_W'($urandom()), gts_pkg::MONTH_W'($urandom()),
                      gts_pkg::READ_W'($urandom()), $urandom_range(7) == 0);
        end
      end
      drain();
    end

    if (tracker.errors == 0 && tracker.drained()) begin
      $display("tb_grouped_temperature_stats: done, clean");
    end else begin
      $display("tb_grouped_temperature_stats: done, errors");
    end
    $finish;
  end

endmodule

### grouped_temperature_stats.f
+incdir+design
design/gts_pkg.sv
design/gts_stats.sv
design/gts_rowbuf.sv
design/grouped_temperature_stats.sv
dv/tb_grouped_temperature_stats.sv
